### design/cds_pkg.sv
`timescale 1ns / 1ps

package cds_pkg;

    localparam int MATRIX_SIZE = 8;
    localparam int ROW_W       = $clog2(MATRIX_SIZE);

    localparam logic [1:0] CFG_TICKS_PER_SCAN   = 2'd0;
    localparam logic [1:0] CFG_SCANS_PER_SECOND = 2'd1;
    localparam logic [1:0] CFG_SCANS_PER_FRAME  = 2'd2;

    localparam logic [7:0] TICKS_PER_SCAN_RST   = 8'd5;
    localparam logic [7:0] SCANS_PER_SECOND_RST = 8'd20;
    localparam logic [7:0] SCANS_PER_FRAME_RST  = 8'd16;

    localparam logic [4:0] HOUR_RST   = 5'd15;
    localparam logic [5:0] MINUTE_RST = 6'd8;
    localparam logic [5:0] SECOND_RST = 6'd55;

    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY      = 5'd24;

    localparam logic [6:0] SEG_BLANK = 7'h7F;

    function automatic logic [7:0] glyph_row(input logic [ROW_W-1:0] idx);
        logic [7:0] row;
        case (idx)
            3'd0:    row = 8'h18;
            3'd1:    row = 8'h3C;
            3'd2:    row = 8'h66;
            3'd3:    row = 8'h66;
            3'd4:    row = 8'h7E;
            3'd5:    row = 8'h7E;
            3'd6:    row = 8'h66;
            3'd7:    row = 8'h66;
            default: row = 8'h00;
        endcase
        return row;
    endfunction

    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] seg;
        case (d)
            4'd0:    seg = 7'h40;
            4'd1:    seg = 7'h79;
            4'd2:    seg = 7'h24;
            4'd3:    seg = 7'h30;
            4'd4:    seg = 7'h19;
            4'd5:    seg = 7'h12;
            4'd6:    seg = 7'h02;
            4'd7:    seg = 7'h78;
            4'd8:    seg = 7'h00;
            4'd9:    seg = 7'h10;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60)      t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] rem;
        rem = v - 6'(tens_of(v)) * 6'd10;
        return rem[3:0];
    endfunction

endpackage

### design/cds_tick_if.sv
`timescale 1ns / 1ps

interface cds_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

### design/cds_result_if.sv
`timescale 1ns / 1ps

interface cds_result_if;
    logic       valid;
    logic       ready;
    logic       scan_event;
    logic [6:0] segments;
    logic [3:0] digit_enables;
    logic       dot;
    logic [7:0] matrix_rows;
    logic [7:0] matrix_columns;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;

    modport source (
        output valid, output scan_event, output segments, output digit_enables,
        output dot, output matrix_rows, output matrix_columns,
        output hours, output minutes, output seconds,
        input ready
    );
    modport sink (
        input valid, input scan_event, input segments, input digit_enables,
        input dot, input matrix_rows, input matrix_columns,
        input hours, input minutes, input seconds,
        output ready
    );
endinterface

### design/clock_display_scanner.sv
`timescale 1ns / 1ps

// Multiplexed HH:MM seven-segment clock with an 8x8 scrolling LED matrix, driven
// by timer ticks. Every tick transfer yields exactly one result transfer that
// reports the pin levels and the clock after that tick. A tick is captured in an
// input register and processed once the result register can advance; then all
// counters, the image and the pin registers update together; the pin and clock
// registers are the result register and hold until the result is taken. One
// tick is accepted every cycle while results are taken. Configuration writes are
// taken in any cycle. New tick-per-scan and scan-per-frame periods take effect at
// the next reload of their countdowns; a new scans-per-second value at the next scan.
module clock_display_scanner (
    input  logic               clk,
    input  logic               rst_n,
    cds_tick_if.sink           timer,
    cds_result_if.source       display,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int RW = cds_pkg::ROW_W;
    localparam int MS = cds_pkg::MATRIX_SIZE;

    logic [7:0]    ticks_per_scan_reg;
    logic [7:0]    scans_per_second_reg;
    logic [7:0]    scans_per_frame_reg;

    logic          in_valid_reg;
    logic          tick_reg;
    logic          out_valid_reg;
    logic          scan_event_reg;

    logic [7:0]    tick_countdown_reg, tick_countdown_next;
    logic [7:0]    scan_total_reg, scan_total_next;
    logic [7:0]    frame_countdown_reg, frame_countdown_next;
    logic [1:0]    digit_slot_reg, digit_slot_next;
    logic [RW-1:0] row_slot_reg, row_slot_next;
    logic [4:0]    hour_count_reg, hour_count_next;
    logic [5:0]    minute_count_reg, minute_count_next;
    logic [5:0]    second_count_reg, second_count_next;
    logic [3:0]    scroll_step_reg, scroll_step_next;
    logic [7:0]    image_reg [MS];
    logic [7:0]    image_next [MS];
    logic [6:0]    segment_pins_reg, segment_pins_next;
    logic [3:0]    digit_pins_reg, digit_pins_next;
    logic          dot_pin_reg, dot_pin_next;
    logic [7:0]    row_pins_reg, row_pins_next;
    logic [7:0]    column_pins_reg, column_pins_next;

    logic          advance;
    logic          step;
    logic          scan_fire;
    logic [3:0]    digit_value;
    logic [7:0]    scan_inc;
    logic [5:0]    second_inc;
    logic [5:0]    minute_inc;
    logic [4:0]    hour_inc;
    logic [2:0]    glyph_shift;

    assign advance     = !out_valid_reg || display.ready;
    assign step        = in_valid_reg && advance;
    assign timer.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_scan_reg   <= cds_pkg::TICKS_PER_SCAN_RST;
            scans_per_second_reg <= cds_pkg::SCANS_PER_SECOND_RST;
            scans_per_frame_reg  <= cds_pkg::SCANS_PER_FRAME_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cds_pkg::CFG_TICKS_PER_SCAN:   ticks_per_scan_reg   <= cfg_data;
                cds_pkg::CFG_SCANS_PER_SECOND: scans_per_second_reg <= cfg_data;
                cds_pkg::CFG_SCANS_PER_FRAME:  scans_per_frame_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            tick_reg     <= 1'b0;
        end
        else if (timer.ready)
        begin
            in_valid_reg <= timer.valid;
            tick_reg     <= timer.tick;
        end
    end

    always_comb
    begin
        tick_countdown_next  = tick_countdown_reg;
        scan_total_next      = scan_total_reg;
        frame_countdown_next = frame_countdown_reg;
        digit_slot_next      = digit_slot_reg;
        row_slot_next        = row_slot_reg;
        hour_count_next      = hour_count_reg;
        minute_count_next    = minute_count_reg;
        second_count_next    = second_count_reg;
        scroll_step_next     = scroll_step_reg;
        segment_pins_next    = segment_pins_reg;
        digit_pins_next      = digit_pins_reg;
        dot_pin_next         = dot_pin_reg;
        row_pins_next        = row_pins_reg;
        column_pins_next     = column_pins_reg;
        for (int i = 0; i < MS; i++)
        begin
            image_next[i] = image_reg[i];
        end
        scan_fire   = 1'b0;
        scan_inc    = scan_total_reg + 8'd1;
        second_inc  = second_count_reg + 6'd1;
        minute_inc  = minute_count_reg + 6'd1;
        hour_inc    = hour_count_reg + 5'd1;
        glyph_shift = 3'(4'd15 - scroll_step_reg);

        case (digit_slot_reg)
            2'd0:    digit_value = 4'(cds_pkg::tens_of(6'(hour_count_reg)));
            2'd1:    digit_value = cds_pkg::units_of(6'(hour_count_reg));
            2'd2:    digit_value = 4'(cds_pkg::tens_of(minute_count_reg));
            default: digit_value = cds_pkg::units_of(minute_count_reg);
        endcase

        if (tick_reg)
        begin
            if (tick_countdown_reg <= 8'd1)
            begin
                tick_countdown_next = ticks_per_scan_reg;
                scan_fire           = 1'b1;
            end
            else
            begin
                tick_countdown_next = tick_countdown_reg - 8'd1;
            end
        end

        if (scan_fire)
        begin
            dot_pin_next      = ~dot_pin_reg;
            digit_pins_next   = ~(4'd1 << digit_slot_reg);
            segment_pins_next = cds_pkg::seg_of(digit_value);
            digit_slot_next   = digit_slot_reg + 2'd1;
            column_pins_next  = ~image_reg[row_slot_reg];
            row_pins_next     = ~(8'd1 << row_slot_reg);
            row_slot_next     = row_slot_reg + RW'(1);

            if (scan_inc >= scans_per_second_reg)
            begin
                scan_total_next = 8'd0;
                if (second_inc >= cds_pkg::SECONDS_PER_MINUTE)
                begin
                    second_count_next = 6'd0;
                    if (minute_inc >= cds_pkg::MINUTES_PER_HOUR)
                    begin
                        minute_count_next = 6'd0;
                        hour_count_next   = (hour_inc >= cds_pkg::HOURS_PER_DAY) ?
                                            5'd0 : hour_inc;
                    end
                    else
                    begin
                        minute_count_next = minute_inc;
                    end
                end
                else
                begin
                    second_count_next = second_inc;
                end
            end
            else
            begin
                scan_total_next = scan_inc;
            end

            if (frame_countdown_reg <= 8'd1)
            begin
                frame_countdown_next = scans_per_frame_reg;
                scroll_step_next     = scroll_step_reg + 4'd1;
                for (int i = 0; i < MS; i++)
                begin
                    if (!scroll_step_reg[3])
                        image_next[i] = image_reg[i] >> 1;
                    else
                        image_next[i] = cds_pkg::glyph_row(RW'(i)) << glyph_shift;
                end
            end
            else
            begin
                frame_countdown_next = frame_countdown_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_countdown_reg  <= cds_pkg::TICKS_PER_SCAN_RST;
            scan_total_reg      <= 8'd0;
            frame_countdown_reg <= cds_pkg::SCANS_PER_FRAME_RST;
            digit_slot_reg      <= 2'd0;
            row_slot_reg        <= '0;
            hour_count_reg      <= cds_pkg::HOUR_RST;
            minute_count_reg    <= cds_pkg::MINUTE_RST;
            second_count_reg    <= cds_pkg::SECOND_RST;
            scroll_step_reg     <= 4'd0;
            segment_pins_reg    <= cds_pkg::SEG_BLANK;
            digit_pins_reg      <= 4'hF;
            dot_pin_reg         <= 1'b1;
            row_pins_reg        <= 8'hFF;
            column_pins_reg     <= 8'hFF;
            for (int i = 0; i < MS; i++)
            begin
                image_reg[i] <= cds_pkg::glyph_row(RW'(i));
            end
        end
        else if (step)
        begin
            tick_countdown_reg  <= tick_countdown_next;
            scan_total_reg      <= scan_total_next;
            frame_countdown_reg <= frame_countdown_next;
            digit_slot_reg      <= digit_slot_next;
            row_slot_reg        <= row_slot_next;
            hour_count_reg      <= hour_count_next;
            minute_count_reg    <= minute_count_next;
            second_count_reg    <= second_count_next;
            scroll_step_reg     <= scroll_step_next;
            segment_pins_reg    <= segment_pins_next;
            digit_pins_reg      <= digit_pins_next;
            dot_pin_reg         <= dot_pin_next;
            row_pins_reg        <= row_pins_next;
            column_pins_reg     <= column_pins_next;
            for (int i = 0; i < MS; i++)
            begin
                image_reg[i] <= image_next[i];
            end
        end
    end

    // pin and clock registers double as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            scan_event_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg  <= 1'b1;
            scan_event_reg <= scan_fire;
        end
        else if (display.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign display.valid          = out_valid_reg;
    assign display.scan_event     = scan_event_reg;
    assign display.segments       = segment_pins_reg;
    assign display.digit_enables  = digit_pins_reg;
    assign display.dot            = dot_pin_reg;
    assign display.matrix_rows    = row_pins_reg;
    assign display.matrix_columns = column_pins_reg;
    assign display.hours          = hour_count_reg;
    assign display.minutes        = minute_count_reg;
    assign display.seconds        = second_count_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        step && scan_fire |=> dot_pin_reg != $past(dot_pin_reg))
        else $error("dot did not toggle on scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && !scan_fire |=> $stable(row_pins_reg) && $stable(digit_pins_reg))
        else $error("pins moved without a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(~digit_pins_reg) && $onehot0(~row_pins_reg))
        else $error("more than one digit or row enabled");

    assert property (@(posedge clk) disable iff (!rst_n)
        hour_count_reg < cds_pkg::HOURS_PER_DAY
        && minute_count_reg < cds_pkg::MINUTES_PER_HOUR
        && second_count_reg < cds_pkg::SECONDS_PER_MINUTE)
        else $error("clock count out of range");
`endif

endmodule
